FILE: rtl/avbq_pkg.sv
// Shared definitions for the adaptive value bucket quantizer.
// Holds sizes, operation codes, the range word, state encodings and the
// command and status bundles between controller and datapath. No dependencies.
package avbq_pkg;

	localparam int MAX_RANGES = 64;
	localparam int ADDR_W     = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int VAL_W      = 8;
	localparam int FUNC_W     = 2;
	localparam int TARGET_W   = 7;
	localparam int TOTAL_W    = 7;
	localparam int CLASS_W    = 6;
	localparam int SPAN_W     = VAL_W + 1;

	localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(5);
	localparam logic [CLASS_W-1:0]  CLASS_MAX    = {CLASS_W{1'b1}};

	// Register word index of target_buckets on the configuration port.
	localparam logic REG_TARGET_BUCKETS = 1'b0;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR    = 2'd0,
		FUNC_ADD      = 2'd1,
		FUNC_MERGE    = 2'd2,
		FUNC_CLASSIFY = 2'd3
	} func_t;

	typedef struct packed {
		logic [VAL_W-1:0] low;
		logic [VAL_W-1:0] high;
	} range_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_EV,
		ST_ADD_CHK,
		ST_INS_RD,
		ST_INS_WR,
		ST_MRG_START,
		ST_MRG_RD,
		ST_MRG_EV,
		ST_MRG_FIX,
		ST_MRG_JOIN,
		ST_MRG_SH_RD,
		ST_MRG_SH_WR,
		ST_CLS_RD,
		ST_CLS_EV,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_ONE,
		IDX_USED,
		IDX_INC,
		IDX_DEC,
		IDX_BEST1
	} idx_op_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDXM1,
		RD_IDXP1,
		RD_BEST1
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NEW,
		WR_SHIFT,
		WR_MERGE
	} wr_sel_t;

	typedef enum logic [1:0] {
		USED_HOLD,
		USED_CLEAR,
		USED_INC,
		USED_DEC
	} used_op_t;

	typedef struct packed {
		logic     accept;
		idx_op_t  idx_op;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wr_sel_t  wr_sel;
		used_op_t used_op;
		logic     set_pos;
		logic     set_full;
		logic     scan_init;
		logic     scan_step;
		logic     cnt_inc;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic v_zero;
		logic idx_eq_used;
		logic idx_ge_used;
		logic idx_eq_pos;
		logic idx_last;
		logic low_eq_v;
		logic low_gt_v;
		logic low_le_v;
		logic tbl_full;
		logic need_merge;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/avbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module avbq_ram #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/avbq_datapath.sv
// Datapath of the quantizer: range memory, scan counters, merge search
// registers and the result register. Depends on avbq_pkg and avbq_ram.
module avbq_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  avbq_pkg::cmd_t                cmd,
	output avbq_pkg::sts_t                sts,
	input  logic [avbq_pkg::VAL_W-1:0]    sample_value,
	input  logic [avbq_pkg::TARGET_W-1:0] target,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [avbq_pkg::TOTAL_W-1:0]  range_total,
	output logic [avbq_pkg::CLASS_W-1:0]  class_index,
	output logic                          table_full
);
	import avbq_pkg::*;

	logic [VAL_W-1:0]    v_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    used_q;
	logic [CNT_W-1:0]    pos_q;
	logic [ADDR_W-1:0]   best_q;
	logic [VAL_W-1:0]    best_low_q;
	logic [SPAN_W-1:0]   best_span_q;
	logic [VAL_W-1:0]    prev_low_q;
	logic [CLASS_W-1:0]  cnt_q;
	logic                full_q;
	logic                out_valid_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [CLASS_W-1:0]  class_q;
	logic                tfull_q;

	logic [CNT_W-1:0]    idx_p1;
	logic [CNT_W-1:0]    idx_m1;
	logic [CNT_W-1:0]    best_p1;
	logic [ADDR_W-1:0]   rd_addr;
	logic [ADDR_W-1:0]   wr_addr;
	range_t              wr_data;
	range_t              rdata;
	logic [VAL_W-1:0]    span;
	logic [TARGET_W-1:0] goal;

	assign idx_p1  = idx_q + CNT_W'(1);
	assign idx_m1  = idx_q - CNT_W'(1);
	assign best_p1 = CNT_W'(best_q) + CNT_W'(1);
	assign span    = rdata.high - prev_low_q;
	assign goal    = (target == '0) ? TARGET_W'(1) : target;

	always_comb begin
		case (cmd.rd_sel)
			RD_IDX:   rd_addr = idx_q[ADDR_W-1:0];
			RD_IDXM1: rd_addr = idx_m1[ADDR_W-1:0];
			RD_IDXP1: rd_addr = idx_p1[ADDR_W-1:0];
			RD_BEST1: rd_addr = best_p1[ADDR_W-1:0];
			default:  rd_addr = idx_q[ADDR_W-1:0];
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_NEW: begin
				wr_addr = pos_q[ADDR_W-1:0];
				wr_data = '{low: v_q, high: v_q};
			end
			WR_SHIFT: begin
				wr_addr = idx_q[ADDR_W-1:0];
				wr_data = rdata;
			end
			WR_MERGE: begin
				wr_addr = best_q;
				wr_data = '{low: best_low_q, high: rdata.high};
			end
			default: begin
				wr_addr = idx_q[ADDR_W-1:0];
				wr_data = rdata;
			end
		endcase
	end

	avbq_ram #(
		.DEPTH (MAX_RANGES),
		.WIDTH ($bits(range_t)),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			used_q      <= '0;
			pos_q       <= '0;
			best_q      <= '0;
			best_span_q <= '0;
			cnt_q       <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.idx_op)
				IDX_HOLD:  idx_q <= idx_q;
				IDX_ZERO:  idx_q <= '0;
				IDX_ONE:   idx_q <= CNT_W'(1);
				IDX_USED:  idx_q <= used_q;
				IDX_INC:   idx_q <= idx_p1;
				IDX_DEC:   idx_q <= idx_m1;
				IDX_BEST1: idx_q <= best_p1;
				default:   idx_q <= idx_q;
			endcase

			case (cmd.used_op)
				USED_HOLD:  used_q <= used_q;
				USED_CLEAR: used_q <= '0;
				USED_INC:   used_q <= used_q + CNT_W'(1);
				USED_DEC:   used_q <= used_q - CNT_W'(1);
				default:    used_q <= used_q;
			endcase

			if (cmd.set_pos) begin
				pos_q <= idx_q;
			end

			if (cmd.accept) begin
				full_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				if (cmd.set_full) begin
					full_q <= 1'b1;
				end
				if (cmd.cnt_inc && cnt_q != CLASS_MAX) begin
					cnt_q <= cnt_q + CLASS_W'(1);
				end
			end

			if (cmd.scan_init) begin
				best_q      <= '0;
				best_span_q <= SPAN_W'(1) << VAL_W;
			end else if (cmd.scan_step && idx_q != '0 && {1'b0, span} < best_span_q) begin
				best_q      <= idx_m1[ADDR_W-1:0];
				best_span_q <= {1'b0, span};
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			v_q <= sample_value;
		end
		if (cmd.scan_step) begin
			prev_low_q <= rdata.low;
			if (idx_q != '0 && {1'b0, span} < best_span_q) begin
				best_low_q <= prev_low_q;
			end
		end
		if (cmd.out_load) begin
			total_q <= TOTAL_W'(used_q);
			class_q <= cnt_q;
			tfull_q <= full_q;
		end
	end

	always_comb begin
		sts.v_zero      = (v_q == '0);
		sts.idx_eq_used = (idx_q == used_q);
		sts.idx_ge_used = (idx_q >= used_q);
		sts.idx_eq_pos  = (idx_q == pos_q);
		sts.idx_last    = (idx_p1 == used_q);
		sts.low_eq_v    = (rdata.low == v_q);
		sts.low_gt_v    = (rdata.low > v_q);
		sts.low_le_v    = (rdata.low <= v_q);
		sts.tbl_full    = (used_q == CNT_W'(MAX_RANGES));
		sts.need_merge  = (used_q > CNT_W'(goal));
		sts.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign range_total = total_q;
	assign class_index = class_q;
	assign table_full  = tfull_q;

endmodule

FILE: rtl/avbq_ctrl.sv
// Controller state machine of the quantizer: sequences memory scans,
// insert shifts and merge passes. Depends on avbq_pkg.
module avbq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [avbq_pkg::FUNC_W-1:0] func,
	output logic                        in_stall,
	input  avbq_pkg::sts_t              sts,
	output avbq_pkg::cmd_t              cmd
);
	import avbq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (func_t'(func))
						FUNC_CLEAR:    state_d = ST_FIN;
						FUNC_ADD:      state_d = ST_ADD_RD;
						FUNC_MERGE:    state_d = ST_MRG_START;
						FUNC_CLASSIFY: state_d = ST_CLS_RD;
						default:       state_d = ST_FIN;
					endcase
				end
			end
			ST_ADD_RD: begin
				if (sts.v_zero) state_d = ST_FIN;
				else if (sts.idx_eq_used) state_d = ST_ADD_CHK;
				else state_d = ST_ADD_EV;
			end
			ST_ADD_EV: begin
				if (sts.low_eq_v) state_d = ST_FIN;
				else if (sts.low_gt_v) state_d = ST_ADD_CHK;
				else state_d = ST_ADD_RD;
			end
			ST_ADD_CHK: state_d = sts.tbl_full ? ST_FIN : ST_INS_RD;
			ST_INS_RD: state_d = sts.idx_eq_pos ? ST_FIN : ST_INS_WR;
			ST_INS_WR: state_d = ST_INS_RD;
			ST_MRG_START: state_d = sts.need_merge ? ST_MRG_RD : ST_FIN;
			ST_MRG_RD: state_d = sts.idx_eq_used ? ST_MRG_FIX : ST_MRG_EV;
			ST_MRG_EV: state_d = ST_MRG_RD;
			ST_MRG_FIX: state_d = ST_MRG_JOIN;
			ST_MRG_JOIN: state_d = ST_MRG_SH_RD;
			ST_MRG_SH_RD: state_d = sts.idx_last ? ST_MRG_START : ST_MRG_SH_WR;
			ST_MRG_SH_WR: state_d = ST_MRG_SH_RD;
			ST_CLS_RD: state_d = sts.idx_ge_used ? ST_FIN : ST_CLS_EV;
			ST_CLS_EV: state_d = sts.low_le_v ? ST_CLS_RD : ST_FIN;
			ST_FIN: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.idx_op   = IDX_HOLD;
		cmd.rd_sel   = RD_IDX;
		cmd.wr_sel   = WR_SHIFT;
		cmd.used_op  = USED_HOLD;
		in_stall     = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (func_t'(func))
						FUNC_CLEAR:    cmd.used_op = USED_CLEAR;
						FUNC_ADD:      cmd.idx_op  = IDX_ZERO;
						FUNC_MERGE:    cmd.idx_op  = IDX_ZERO;
						FUNC_CLASSIFY: cmd.idx_op  = IDX_ONE;
						default:       cmd.idx_op  = IDX_HOLD;
					endcase
				end
			end
			ST_ADD_RD: begin
				if (sts.v_zero) begin
					cmd.idx_op = IDX_HOLD;
				end else if (sts.idx_eq_used) begin
					cmd.set_pos = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
				end
			end
			ST_ADD_EV: begin
				if (sts.low_eq_v) begin
					cmd.idx_op = IDX_HOLD;
				end else if (sts.low_gt_v) begin
					cmd.set_pos = 1'b1;
				end else begin
					cmd.idx_op = IDX_INC;
				end
			end
			ST_ADD_CHK: begin
				if (sts.tbl_full) cmd.set_full = 1'b1;
				else cmd.idx_op = IDX_USED;
			end
			ST_INS_RD: begin
				if (sts.idx_eq_pos) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WR_NEW;
					cmd.used_op = USED_INC;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDXM1;
				end
			end
			ST_INS_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				cmd.idx_op = IDX_DEC;
			end
			ST_MRG_START: begin
				if (sts.need_merge) begin
					cmd.scan_init = 1'b1;
					cmd.idx_op    = IDX_ZERO;
				end
			end
			ST_MRG_RD: begin
				if (!sts.idx_eq_used) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
				end
			end
			ST_MRG_EV: begin
				cmd.scan_step = 1'b1;
				cmd.idx_op    = IDX_INC;
			end
			ST_MRG_FIX: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_BEST1;
			end
			ST_MRG_JOIN: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_MERGE;
				cmd.idx_op = IDX_BEST1;
			end
			ST_MRG_SH_RD: begin
				if (sts.idx_last) begin
					cmd.used_op = USED_DEC;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDXP1;
				end
			end
			ST_MRG_SH_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				cmd.idx_op = IDX_INC;
			end
			ST_CLS_RD: begin
				if (!sts.idx_ge_used) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
				end
			end
			ST_CLS_EV: begin
				if (sts.low_le_v) begin
					cmd.cnt_inc = 1'b1;
					cmd.idx_op  = IDX_INC;
				end
			end
			ST_FIN: begin
				cmd.out_load = sts.out_free;
			end
			default: cmd.idx_op = IDX_HOLD;
		endcase
	end

endmodule

FILE: rtl/adaptive_value_bucket_quantizer.sv
// Steps: clear goes straight to the result; add scans for the insert place p, then shifts
// entries p to n-1 up a place (n = count); classify scans entries up to the class c; merge,
// per merged pair, scans all n entries for the narrowest pair, joins it at left index b and
// shifts the entries above it down. One item is processed at a time; every scan and shift
// step goes through the single read port of the range memory, whose read data is registered.
// Reset (arst_n low, asynchronous): count 0, target_buckets 5, no result; memory not cleared.
module adaptive_value_bucket_quantizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [avbq_pkg::FUNC_W-1:0]   func,
	input  logic [avbq_pkg::VAL_W-1:0]    sample_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [avbq_pkg::TOTAL_W-1:0]  range_total,
	output logic [avbq_pkg::CLASS_W-1:0]  class_index,
	output logic                          table_full,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import avbq_pkg::*;

	// The configuration port holds a single register, target_buckets, at byte
	// address 0. The word index is paddr[2]; a write to the next word is ignored.
	logic [TARGET_W-1:0] target_q;
	logic                cfg_we;
	cmd_t                cmd;
	sts_t                sts;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_TARGET_BUCKETS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg_we) begin
			target_q <= pwdata[TARGET_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_TARGET_BUCKETS) ? {{(32-TARGET_W){1'b0}}, target_q} : '0;

	// The controller accepts a beat only in its idle state and walks the range
	// memory one entry at a time; the datapath holds the finished result in its
	// output register, so the next beat is taken while a result still waits.
	avbq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.func    (func),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	avbq_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample_value(sample_value),
		.target      (target_q),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.range_total (range_total),
		.class_index (class_index),
		.table_full  (table_full)
	);

endmodule

FILE: rtl/avbq_checker.sv
// Port-level checks for the quantizer, attached to the top level by bind.
// Depends only on the top level's ports.
module avbq_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  func,
	input logic [7:0]  sample_value,
	input logic        out_valid,
	input logic        out_stall,
	input logic [6:0]  range_total,
	input logic [5:0]  class_index,
	input logic        table_full,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// A held result beat stays up while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// The table_full flag is only shown with the table at capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> range_total == 7'd64)
		else $error("table_full flagged below capacity");

	// A nonzero class never reaches the number of ranges.
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && class_index != 6'd0 |-> {1'b0, class_index} < range_total && !table_full)
		else $error("class index out of range");

	// An accepted beat keeps the input closed in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

endmodule

bind adaptive_value_bucket_quantizer avbq_props u_avbq_props (.*);
